>>> rtl/uslm_pkg.sv
// Package for the UDP sequence loss monitor: field widths, reset values and
// the report kind codes. Depends on nothing; imported by the core and its checker.
`default_nettype none

package uslm_pkg;

  localparam int unsigned SEQ_W        = 32;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned TIME_W       = 48;
  localparam int unsigned SESSION_W    = 8;
  localparam int unsigned LATE_W       = 32;
  localparam int unsigned INTERVAL_W   = 22;
  localparam int unsigned CNT_W_DEFAULT = 48;

  // Input beat: seq_id, byte_count, now_ms from the lowest bit up.
  localparam int unsigned IN_DATA_W  = SEQ_W + LEN_W + TIME_W;
  // Output beat: session, elapsed, bytes, datagrams, dropped, out-of-order.
  localparam int unsigned OUT_DATA_W = SESSION_W + 4 * TIME_W + LATE_W;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(1000);

  typedef enum logic {
    KIND_INTERIM = 1'b0,
    KIND_FINAL   = 1'b1
  } report_kind_t;

endpackage : uslm_pkg

`default_nettype wire

>>> rtl/udp_sequence_loss_monitor_core.sv
// UDP sequence loss monitor: counts datagrams, bytes, sequence gaps and late
// ids per session and per report window. Depends on uslm_pkg.
`default_nettype none

// Channel     | Direction | Beat contents
// ------------+-----------+---------------------------------------------------
// s_axis      | in        | one received datagram header (seq, length, time)
// m_axis      | out       | one interim or final report (kind in tuser)
// cfg_wr      | in        | report interval in milliseconds, write only
//
// One datagram is taken every cycle while no report is stalled. A beat is first held
// in the input register and is then resolved by a single pass of adders and compares
// that updates the session and window counters and loads the result register, which
// drives m_axis.
// Reset clears the session state and sets the interval to 1000 ms.
// While a report waits with m_axis_tready low, the result register holds it,
// the input register keeps its beat and s_axis_tready falls once that is full.

module udp_sequence_loss_monitor_core #(
  parameter int unsigned COUNTER_WIDTH = uslm_pkg::CNT_W_DEFAULT
) (
  input  wire                               clk,
  input  wire                               rst,
  // Register write port.
  input  wire                               cfg_wr_en,
  input  wire [uslm_pkg::INTERVAL_W-1:0]    cfg_wr_data,
  // Datagram headers.
  input  wire                               s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: seq_id [31:0], byte_count [47:32], now_ms [95:48]
  input  wire [uslm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // Reports.
  output logic                              m_axis_tvalid,
  input  wire                               m_axis_tready,
  // tdata: session_number [7:0], elapsed_ms [55:8], bytes_total [103:56],
  //        datagrams_total [151:104], dropped_total [199:152],
  //        out_of_order_total [231:200]
  output logic [uslm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // tuser: report_kind [0]
  output logic                              m_axis_tuser
);

  import uslm_pkg::*;

  localparam int unsigned CW = COUNTER_WIDTH;

  // Configuration register.
  logic [INTERVAL_W-1:0] report_interval_ms;

  // Input register.
  logic                     in_valid;
  logic signed [SEQ_W-1:0]  in_seq_id;
  logic [LEN_W-1:0]         in_byte_count;
  logic [TIME_W-1:0]        in_now_ms;

  // Session and window state.
  logic                  idle, idle_next;
  logic [SESSION_W-1:0]  session_count, session_count_next;
  logic [SEQ_W-1:0]      expected_id, expected_id_next;
  logic [TIME_W-1:0]     session_start_ms, session_start_ms_next;
  logic [CW-1:0]         sum_bytes, sum_bytes_next;
  logic [CW-1:0]         sum_datagrams, sum_datagrams_next;
  logic [CW-1:0]         sum_dropped, sum_dropped_next;
  logic [LATE_W-1:0]     sum_late, sum_late_next;
  logic [TIME_W-1:0]     window_start_ms, window_start_ms_next;
  logic                  window_open, window_open_next;
  logic [CW-1:0]         window_bytes, window_bytes_next;
  logic [CW-1:0]         window_datagrams, window_datagrams_next;
  logic [CW-1:0]         window_dropped, window_dropped_next;

  // Result register.
  logic                  res_valid;
  report_kind_t          res_kind;
  logic [SESSION_W-1:0]  res_session;
  logic [TIME_W-1:0]     res_elapsed;
  logic [TIME_W-1:0]     res_bytes;
  logic [TIME_W-1:0]     res_datagrams;
  logic [TIME_W-1:0]     res_dropped;
  logic [LATE_W-1:0]     res_late;

  // Single pass results.
  logic                  emit;
  report_kind_t          emit_kind;
  logic [TIME_W-1:0]     emit_elapsed;
  logic [CW-1:0]         emit_bytes, emit_datagrams, emit_dropped;
  logic [LATE_W-1:0]     emit_late;

  logic                  advance;
  logic                  work;
  logic                  open_session;
  logic [SEQ_W-1:0]      id_u;
  logic [SEQ_W-1:0]      drop;
  logic [CW-1:0]         drop_cnt;
  logic [CW-1:0]         len_cnt;
  logic [TIME_W-1:0]     window_diff;

  // The pipeline moves whenever the result register is empty or being drained.
  assign advance       = !res_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;
  assign work          = in_valid && advance;

  assign id_u         = $unsigned(in_seq_id);
  assign open_session = idle && (id_u == '0);
  assign len_cnt      = CW'(in_byte_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      report_interval_ms <= INTERVAL_RESET;
    end else if (cfg_wr_en) begin
      report_interval_ms <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_seq_id     <= $signed(s_axis_tdata[SEQ_W-1:0]);
      in_byte_count <= s_axis_tdata[SEQ_W+LEN_W-1:SEQ_W];
      in_now_ms     <= s_axis_tdata[IN_DATA_W-1:SEQ_W+LEN_W];
    end
  end

  // Next state. A datagram with id 0 while idle first opens the session (session
  // count advanced, all other counters cleared, start time taken) and is then counted like any other.
  always_comb begin
    idle_next             = idle;
    session_count_next    = session_count;
    expected_id_next      = expected_id;
    session_start_ms_next = session_start_ms;
    sum_bytes_next        = sum_bytes;
    sum_datagrams_next    = sum_datagrams;
    sum_dropped_next      = sum_dropped;
    sum_late_next         = sum_late;
    window_start_ms_next  = window_start_ms;
    window_open_next      = window_open;
    window_bytes_next     = window_bytes;
    window_datagrams_next = window_datagrams;
    window_dropped_next   = window_dropped;
    emit                  = 1'b0;
    emit_kind             = KIND_INTERIM;
    emit_elapsed          = '0;
    emit_bytes            = '0;
    emit_datagrams        = '0;
    emit_dropped          = '0;
    emit_late             = '0;
    drop                  = '0;
    drop_cnt              = '0;
    window_diff           = '0;

    if (open_session) begin
      session_count_next    = session_count + SESSION_W'(1);
      session_start_ms_next = in_now_ms;
      expected_id_next      = '0;
      sum_bytes_next        = '0;
      sum_datagrams_next    = '0;
      sum_dropped_next      = '0;
      sum_late_next         = '0;
      window_start_ms_next  = '0;
      window_open_next      = 1'b0;
      window_bytes_next     = '0;
      window_datagrams_next = '0;
      window_dropped_next   = '0;
      idle_next             = 1'b0;
    end

    if (!idle || open_session) begin
      if (in_seq_id[SEQ_W-1]) begin
        // End of test: report the session totals and fall idle.
        emit           = 1'b1;
        emit_kind      = KIND_FINAL;
        emit_elapsed   = in_now_ms - session_start_ms;
        emit_bytes     = sum_bytes;
        emit_datagrams = sum_datagrams;
        emit_dropped   = sum_dropped;
        emit_late      = sum_late;
        idle_next      = 1'b1;
      end else begin
        if (id_u > expected_id_next) begin
          drop             = id_u - expected_id_next;
          expected_id_next = id_u + SEQ_W'(1);
        end else if (id_u == expected_id_next) begin
          expected_id_next = expected_id_next + SEQ_W'(1);
        end else begin
          sum_late_next = sum_late_next + LATE_W'(1);
        end
        drop_cnt           = CW'(drop);
        sum_dropped_next   = sum_dropped_next + drop_cnt;
        sum_datagrams_next = sum_datagrams_next + CW'(1);
        sum_bytes_next     = sum_bytes_next + len_cnt;

        if (report_interval_ms != '0) begin
          window_datagrams_next = window_datagrams_next + CW'(1);
          window_dropped_next   = window_dropped_next + drop_cnt;
          window_bytes_next     = window_bytes_next + len_cnt;
          window_diff           = in_now_ms - window_start_ms_next;
          if (window_open_next) begin
            if (window_diff >= TIME_W'(report_interval_ms)) begin
              emit                  = 1'b1;
              emit_kind             = KIND_INTERIM;
              emit_elapsed          = window_diff;
              emit_bytes            = window_bytes_next;
              emit_datagrams        = window_datagrams_next;
              emit_dropped          = window_dropped_next;
              window_start_ms_next  = '0;
              window_open_next      = 1'b0;
              window_bytes_next     = '0;
              window_datagrams_next = '0;
              window_dropped_next   = '0;
            end
          end else begin
            // First datagram of a window only marks its start.
            window_start_ms_next = in_now_ms;
            window_open_next     = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle             <= 1'b1;
      session_count    <= '0;
      expected_id      <= '0;
      session_start_ms <= '0;
      sum_bytes        <= '0;
      sum_datagrams    <= '0;
      sum_dropped      <= '0;
      sum_late         <= '0;
      window_start_ms  <= '0;
      window_open      <= 1'b0;
      window_bytes     <= '0;
      window_datagrams <= '0;
      window_dropped   <= '0;
    end else if (work) begin
      idle             <= idle_next;
      session_count    <= session_count_next;
      expected_id      <= expected_id_next;
      session_start_ms <= session_start_ms_next;
      sum_bytes        <= sum_bytes_next;
      sum_datagrams    <= sum_datagrams_next;
      sum_dropped      <= sum_dropped_next;
      sum_late         <= sum_late_next;
      window_start_ms  <= window_start_ms_next;
      window_open      <= window_open_next;
      window_bytes     <= window_bytes_next;
      window_datagrams <= window_datagrams_next;
      window_dropped   <= window_dropped_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= work && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (work && emit) begin
      res_kind      <= emit_kind;
      res_session   <= session_count_next;
      res_elapsed   <= emit_elapsed;
      res_bytes     <= TIME_W'(emit_bytes);
      res_datagrams <= TIME_W'(emit_datagrams);
      res_dropped   <= TIME_W'(emit_dropped);
      res_late      <= emit_late;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tuser  = res_kind;
  assign m_axis_tdata  = {res_late, res_dropped, res_datagrams, res_bytes,
                          res_elapsed, res_session};

endmodule : udp_sequence_loss_monitor_core

`default_nettype wire

>>> rtl/uslm_checker.sv
// Port-level checks for the UDP sequence loss monitor, bound to its top level.
// Depends on uslm_pkg and udp_sequence_loss_monitor_core.
`default_nettype none

module uslm_checker (
  input wire                             clk,
  input wire                             rst,
  input wire                             s_axis_tvalid,
  input wire                             s_axis_tready,
  input wire                             m_axis_tvalid,
  input wire                             m_axis_tready,
  input wire [uslm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire                             m_axis_tuser
);

  import uslm_pkg::*;

  localparam int unsigned LATE_LSB = OUT_DATA_W - LATE_W;

  // A stalled report keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("report changed while stalled");

  // Interim reports never carry a late count.
  a_interim_no_late: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == KIND_INTERIM) |->
      (m_axis_tdata[OUT_DATA_W-1:LATE_LSB] == '0))
    else $error("interim report with nonzero out-of-order count");

  // No report is pending straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("report pending after reset");

  // With nothing waiting on the output, input is never held off.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output empty");

endmodule : uslm_checker

bind udp_sequence_loss_monitor_core uslm_checker u_uslm_checker (.*);

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for udp_sequence_loss_monitor_core: directed datagram
// rows, then randomised sessions under several report intervals.
// Depends on uslm_pkg and the core RTL; every report is checked against a queued expectation.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uslm_pkg::*;

  localparam int unsigned CNT_W           = CNT_W_DEFAULT;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = INTERVAL_W'(3600000);
  localparam int unsigned MAX_GAP         = 12;
  localparam int unsigned ITEMS_PER_PHASE = 125;
  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned SETTLE_CYCLES   = 4;

  // One expected or observed report, with the fields in their natural widths.
  typedef struct packed {
    report_kind_t         kind;
    logic [SESSION_W-1:0] session;
    logic [TIME_W-1:0]    elapsed;
    logic [TIME_W-1:0]    bytes;
    logic [TIME_W-1:0]    dgrams;
    logic [TIME_W-1:0]    drops;
    logic [LATE_W-1:0]    late;
  } report_t;

  // How a stimulus row obtains its expectation.
  typedef enum logic [1:0] {
    ROW_PREDICT   = 2'd0,
    ROW_NO_REPORT = 2'd1,
    ROW_REPORT    = 2'd2
  } row_mode_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [LEN_W-1:0]  len;
    logic [TIME_W-1:0] now;
    row_mode_t         mode;
    report_t           rep;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_wr_en = 1'b0;
  logic [INTERVAL_W-1:0]   cfg_wr_data = '0;
  logic                    s_axis_tvalid = 1'b0;
  wire                     s_axis_tready;
  // tdata: seq_id, byte_count, now_ms
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  wire                     m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // tdata: session_number, elapsed_ms, bytes_total, datagrams_total,
  //        dropped_total, out_of_order_total
  wire  [OUT_DATA_W-1:0]   m_axis_tdata;
  // tuser: report_kind
  wire                     m_axis_tuser;

  udp_sequence_loss_monitor_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  initial begin : run_limit
    #1000000;
    $display("FAIL");
    $finish;
  end

  // Shadow of the monitor's state, advanced once per accepted datagram beat.
  logic [INTERVAL_W-1:0] interval_q;
  bit                    mon_idle;
  logic [SESSION_W-1:0]  sess_no;
  logic [SEQ_W-1:0]      exp_seq;
  logic [TIME_W-1:0]     sess_start;
  logic [CNT_W-1:0]      tot_bytes, tot_dgrams, tot_drops;
  logic [LATE_W-1:0]     tot_late;
  bit                    win_open;
  logic [TIME_W-1:0]     win_start;
  logic [CNT_W-1:0]      win_bytes, win_dgrams, win_drops;

  report_t     pending_reports[$];
  int unsigned fail_count = 0;
  bit          no_gaps = 1'b0;

  function automatic void clear_window();
    win_open   = 1'b0;
    win_start  = '0;
    win_bytes  = '0;
    win_dgrams = '0;
    win_drops  = '0;
  endfunction

  // Advances the shadow state by one datagram. Returns 1 when a report is due;
  // counted is 0 when the datagram is dropped on the floor while idle.
  function automatic bit predict_datagram(input logic [SEQ_W-1:0] seq,
                                          input logic [LEN_W-1:0] len,
                                          input logic [TIME_W-1:0] now,
                                          output bit counted,
                                          output report_t rep);
    logic [SEQ_W-1:0]  gap;
    logic [TIME_W-1:0] diff;
    gap     = '0;
    rep     = '0;
    counted = 1'b0;
    if (mon_idle) begin
      // Only id 0 opens a session; anything else passes unseen.
      if (seq != '0) return 1'b0;
      sess_no    = sess_no + 1'b1;
      sess_start = now;
      tot_bytes  = '0;
      tot_dgrams = '0;
      tot_drops  = '0;
      tot_late   = '0;
      exp_seq    = '0;
      clear_window();
      mon_idle   = 1'b0;
    end
    counted = 1'b1;
    if (seq[SEQ_W-1]) begin
      // End of test: session totals go out and the window counters stay put.
      rep.kind    = KIND_FINAL;
      rep.session = sess_no;
      rep.elapsed = now - sess_start;
      rep.bytes   = TIME_W'(tot_bytes);
      rep.dgrams  = TIME_W'(tot_dgrams);
      rep.drops   = TIME_W'(tot_drops);
      rep.late    = tot_late;
      mon_idle    = 1'b1;
      return 1'b1;
    end
    if (seq > exp_seq) begin
      gap       = seq - exp_seq;
      tot_drops = tot_drops + CNT_W'(gap);
      exp_seq   = seq + 1'b1;
    end else if (seq == exp_seq) begin
      exp_seq = exp_seq + 1'b1;
    end else begin
      tot_late = tot_late + 1'b1;
    end
    tot_dgrams = tot_dgrams + 1'b1;
    tot_bytes  = tot_bytes + CNT_W'(len);
    if (interval_q != '0) begin
      win_dgrams = win_dgrams + 1'b1;
      win_drops  = win_drops + CNT_W'(gap);
      win_bytes  = win_bytes + CNT_W'(len);
      if (win_open) begin
        diff = now - win_start;
        if (diff >= TIME_W'(interval_q)) begin
          rep.kind    = KIND_INTERIM;
          rep.session = sess_no;
          rep.elapsed = diff;
          rep.bytes   = TIME_W'(win_bytes);
          rep.dgrams  = TIME_W'(win_dgrams);
          rep.drops   = TIME_W'(win_drops);
          rep.late    = '0;
          clear_window();
          return 1'b1;
        end
      end else begin
        // The first datagram of a window only marks its start.
        win_start = now;
        win_open  = 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int unsigned draw_gap();
    return no_gaps ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Presents one datagram beat and returns at the edge that accepts it, with
  // the expectation already queued. Called at a rising edge.
  task automatic send_datagram(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                               input logic [TIME_W-1:0] now, input row_mode_t mode,
                               input report_t typed_rep, output bit counted);
    int unsigned gap;
    report_t     rep;
    bit          has_rep;
    gap = draw_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {now, len, seq};
    // Inputs and outputs only move at rising edges, so the level at the falling
    // edge is what the next rising edge will see.
    do @(negedge clk); while (!s_axis_tready);
    @(posedge clk);
    has_rep = predict_datagram(seq, len, now, counted, rep);
    case (mode)
      ROW_PREDICT: begin
        if (has_rep) pending_reports.push_back(rep);
      end
      ROW_REPORT: begin
        pending_reports.push_back(typed_rep);
      end
      default: begin
      end
    endcase
  endtask

  // Drops valid and waits for every queued report, then for the pipeline to empty.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [INTERVAL_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    interval_q   = value;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] exp_v, input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  task automatic check_report(input report_t got);
    report_t exp_r;
    if (pending_reports.size() == 0) begin
      $display("%0t: unexpected report, kind %0d session %0d elapsed %0h", $time,
               got.kind, got.session, got.elapsed);
      fail_count++;
    end else begin
      exp_r = pending_reports.pop_front();
      cmp_field("report_kind", 64'(exp_r.kind), 64'(got.kind));
      cmp_field("session_number", 64'(exp_r.session), 64'(got.session));
      cmp_field("elapsed_ms", 64'(exp_r.elapsed), 64'(got.elapsed));
      cmp_field("bytes_total", 64'(exp_r.bytes), 64'(got.bytes));
      cmp_field("datagrams_total", 64'(exp_r.dgrams), 64'(got.dgrams));
      cmp_field("dropped_total", 64'(exp_r.drops), 64'(got.drops));
      cmp_field("out_of_order_total", 64'(exp_r.late), 64'(got.late));
    end
  endtask

  // Report side: stalls a random number of cycles before each beat.
  initial begin : report_sink
    report_t     got;
    int unsigned stall;
    @(negedge rst);
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(negedge clk); while (!m_axis_tvalid);
      got.kind    = report_kind_t'(m_axis_tuser);
      got.session = m_axis_tdata[0 +: SESSION_W];
      got.elapsed = m_axis_tdata[SESSION_W +: TIME_W];
      got.bytes   = m_axis_tdata[SESSION_W + TIME_W +: TIME_W];
      got.dgrams  = m_axis_tdata[SESSION_W + 2 * TIME_W +: TIME_W];
      got.drops   = m_axis_tdata[SESSION_W + 3 * TIME_W +: TIME_W];
      got.late    = m_axis_tdata[SESSION_W + 4 * TIME_W +: LATE_W];
      @(posedge clk);
      check_report(got);
    end
  end

  task automatic add_row(input logic [SEQ_W-1:0] seq, input logic [LEN_W-1:0] len,
                         input logic [TIME_W-1:0] now, input row_mode_t mode,
                         input report_t rep, inout stim_row_t rows[$]);
    stim_row_t row;
    row.seq  = seq;
    row.len  = len;
    row.now  = now;
    row.mode = mode;
    row.rep  = rep;
    rows.push_back(row);
  endtask

  initial begin : stimulus
    stim_row_t             rows[$];
    report_t               typed;
    bit                    counted;
    int unsigned           done_items;
    int unsigned           pick;
    logic [INTERVAL_W-1:0] iv;
    logic [TIME_W-1:0]     cur_time;
    logic [SEQ_W-1:0]      seq;
    int unsigned           step_cap;

    interval_q = INTERVAL_RESET;
    mon_idle   = 1'b1;
    sess_no    = '0;
    exp_seq    = '0;
    sess_start = '0;
    tot_bytes  = '0;
    tot_dgrams = '0;
    tot_drops  = '0;
    tot_late   = '0;
    clear_window();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at the reset interval of 1000 ms.
    typed = '0;
    // Idle: non-zero ids, positive or negative, are ignored.
    add_row(32'd5, 16'hFFFF, 48'hFFFF_FFFF_FFFF, ROW_NO_REPORT, typed, rows);
    add_row(32'h8000_0000, 16'd0, 48'd0, ROW_NO_REPORT, typed, rows);
    // Session 1 opens at time 0, which is a valid window start.
    add_row(32'd0, 16'hFFFF, 48'd0, ROW_NO_REPORT, typed, rows);
    add_row(32'd1, 16'd100, 48'd500, ROW_PREDICT, typed, rows);
    add_row(32'd5, 16'd0, 48'd999, ROW_PREDICT, typed, rows);          // gap of three
    add_row(32'd3, 16'd1, 48'd1000, ROW_PREDICT, typed, rows);         // late, window due
    add_row(32'd0, 16'd2, 48'd1001, ROW_PREDICT, typed, rows);         // id 0 mid-session
    add_row(32'h7FFF_FFFF, 16'd3, 48'd1500, ROW_PREDICT, typed, rows); // largest id
    add_row(32'h7FFF_FFFF, 16'd4, 48'd2001, ROW_PREDICT, typed, rows); // repeat is late
    add_row(32'hFFFF_FFFF, 16'd0, 48'd2002, ROW_PREDICT, typed, rows);
    // Session 2 straddles the wrap of the millisecond clock.
    add_row(32'd0, 16'd10, 48'hFFFF_FFFF_FF00, ROW_PREDICT, typed, rows);
    add_row(32'd1, 16'd20, 48'd743, ROW_PREDICT, typed, rows);
    add_row(32'd2, 16'd30, 48'd744, ROW_PREDICT, typed, rows);
    add_row(32'h8000_0000, 16'd40, 48'd5, ROW_PREDICT, typed, rows);
    // Session 3 ends straight after opening.
    add_row(32'd0, 16'd7, 48'd100, ROW_NO_REPORT, typed, rows);
    typed.kind    = KIND_FINAL;
    typed.session = 8'd3;
    typed.elapsed = 48'd50;
    typed.bytes   = 48'd7;
    typed.dgrams  = 48'd1;
    add_row(32'hFFFF_FFFF, 16'd0, 48'd150, ROW_REPORT, typed, rows);
    typed = '0;
    add_row(32'hFFFF_FFFF, 16'd9, 48'd160, ROW_NO_REPORT, typed, rows);
    // Session 4: the widest gap straight after opening, then a late id.
    add_row(32'd0, 16'd0, 48'd5, ROW_PREDICT, typed, rows);
    add_row(32'h7FFF_FFFF, 16'hFFFF, 48'd6, ROW_PREDICT, typed, rows);
    add_row(32'd1, 16'd0, 48'd1005, ROW_PREDICT, typed, rows);
    add_row(32'hFFFF_FFFE, 16'd1, 48'd2000, ROW_PREDICT, typed, rows);

    foreach (rows[i])
      send_datagram(rows[i].seq, rows[i].len, rows[i].now, rows[i].mode, rows[i].rep, counted);

    // Random sessions, one interval setting per phase, extremes included.
    typed = '0;
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      drain();
      case (phase)
        0: iv = '0;
        1: iv = INTERVAL_W'(1);
        2: iv = INTERVAL_MAX;
        3: iv = INTERVAL_W'($urandom_range(2, 40));
        4: iv = INTERVAL_W'($urandom_range(0, 3600000));
        default: iv = INTERVAL_RESET;
      endcase
      write_interval(iv);
      step_cap   = (iv == '0) ? 5000 : int'(iv) / 3 + 1;
      cur_time   = {16'($urandom), $urandom};
      done_items = 0;
      while (done_items < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 39) == 0) no_gaps = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 99);
        if (mon_idle) begin
          // Mostly open a new session; now and then a stray id.
          if (pick < 12) begin
            seq = $urandom;
            if (seq == '0) seq = 32'd1;
          end else begin
            seq = '0;
          end
        end else if (pick < 3) begin
          seq = {1'b1, 31'($urandom)};
        end else if (pick < 65) begin
          seq = exp_seq;
        end else if (pick < 80) begin
          seq = exp_seq + SEQ_W'($urandom_range(1, 8));
        end else if (pick < 92) begin
          seq = exp_seq - SEQ_W'($urandom_range(1, 8));
        end else if (pick < 97) begin
          seq = $urandom;
        end else begin
          seq = '0;
        end
        // Time mostly creeps forward; an occasional jump may run backwards.
        if ($urandom_range(0, 49) == 0)
          cur_time = {16'($urandom), $urandom};
        else
          cur_time = cur_time + TIME_W'($urandom_range(0, step_cap));
        send_datagram(seq, 16'($urandom), cur_time, ROW_PREDICT, typed, counted);
        if (counted) done_items++;
      end
    end

    no_gaps = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule : tb

`default_nettype wire
